// ===== rtl/lgs_pkg.sv =====
// Shared types and constants for the Game of Life grid block.
// Used by the top level and the testbench.
`default_nettype none

package lgs_pkg;

    // Fixed widths of the command and configuration fields.
    localparam int CMD_W      = 2;
    localparam int ROW_W      = 5;
    localparam int COL_W      = 6;
    localparam int COLS_W     = 7;
    localparam int ROWS_W     = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [COLS_W-1:0] COLS_RESET = 7'd60;
    localparam logic [ROWS_W-1:0] ROWS_RESET = 6'd30;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CELL,
        ST_LOAD,
        ST_SWEEP
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/lgs_grid_mem.sv =====
// Grid storage: one row of cells per entry, one write and one registered read a cycle.
// Per-row valid bits make unwritten rows read as all dead after reset. Standalone.
`default_nettype none

module lgs_grid_mem #(
    parameter int ROWS = 32,
    parameter int COLS = 64
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    wr_en,
    input  wire logic [$clog2(ROWS)-1:0] wr_addr,
    input  wire logic [COLS-1:0]         wr_data,
    input  wire logic [$clog2(ROWS)-1:0] rd_addr,
    output logic      [COLS-1:0]         rd_data
);

    logic [COLS-1:0] mem [ROWS];
    logic [ROWS-1:0] row_valid_reg;
    logic [COLS-1:0] rd_data_reg;
    logic            rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
    end

    // A row never written since reset holds only dead cells.
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/lgs_row_unit.sv =====
// Row update unit: applies the B3/S23 rule to one row from the rows above and below.
// Shared by every row of a generation step; no package dependencies.
`default_nettype none

module lgs_row_unit #(
    parameter int COLS = 64
) (
    input  wire logic [COLS-1:0] above,
    input  wire logic [COLS-1:0] cur,
    input  wire logic [COLS-1:0] below,
    input  wire logic [COLS-1:0] col_mask,
    output logic      [COLS-1:0] new_row,
    output logic                 changed
);

    logic [COLS+1:0] ap;
    logic [COLS+1:0] cp;
    logic [COLS+1:0] bp;
    logic [3:0]      cnt;

    always_comb
    begin
        // Pad with a dead column on each side; masked columns count as dead too.
        ap = {1'b0, above & col_mask, 1'b0};
        cp = {1'b0, cur & col_mask, 1'b0};
        bp = {1'b0, below & col_mask, 1'b0};
        cnt = '0;
        for (int c = 0; c < COLS; c++)
        begin
            cnt = 4'(ap[c]) + 4'(ap[c+1]) + 4'(ap[c+2])
                + 4'(cp[c]) + 4'(cp[c+2])
                + 4'(bp[c]) + 4'(bp[c+1]) + 4'(bp[c+2]);
            if (col_mask[c])
            begin
                new_row[c] = (cnt == 4'd3) || (cur[c] && (cnt == 4'd2));
            end
            else
            begin
                new_row[c] = cur[c];
            end
        end
        changed = |((new_row ^ cur) & col_mask);
    end

endmodule

`default_nettype wire

// ===== rtl/life_grid_generation_step.sv =====
// Game of Life grid (B3/S23) with cell write, cell read and one-generation step.
// Depends on lgs_pkg, lgs_grid_mem and lgs_row_unit.
// A write or read answers after ST_CELL, an unused command from idle; a step runs a load
// cycle, then one row per cycle through the shared row unit over the rows in use (at most
// MAX_ROWS), or answers from idle with none in use. busy is low in the result cycle, so the
// next item may start then; results cannot be held off. Reset clears the grid to 60 x 30.
`default_nettype none

module life_grid_generation_step
    import lgs_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [CMD_W-1:0]      cmd,
    input  wire logic [ROW_W-1:0]      row,
    input  wire logic [COL_W-1:0]      col,
    input  wire logic                  value,
    output logic                       busy,
    output logic                       done,
    output logic                       cell_res,
    output logic                       stable,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CW  = $clog2(MAX_COLS);
    localparam int RCW = ($clog2(MAX_ROWS + 1) > ROWS_W) ? $clog2(MAX_ROWS + 1) : ROWS_W;
    localparam int CCW = ($clog2(MAX_COLS + 1) > COLS_W) ? $clog2(MAX_COLS + 1) : COLS_W;

    state_t              state_reg, state_next;
    logic [COLS_W-1:0]   cols_in_use_reg;
    logic [ROWS_W-1:0]   rows_in_use_reg;
    logic [CMD_W-1:0]    req_cmd_reg, req_cmd_next;
    logic [ROW_W-1:0]    req_row_reg, req_row_next;
    logic [COL_W-1:0]    req_col_reg, req_col_next;
    logic                req_value_reg, req_value_next;
    logic [RW-1:0]       sweep_row_reg, sweep_row_next;
    logic [MAX_COLS-1:0] above_reg, above_next;
    logic [MAX_COLS-1:0] cur_reg, cur_next;
    logic                diff_reg, diff_next;
    logic                done_reg, done_next;
    logic                cell_res_reg, cell_res_next;
    logic                stable_reg, stable_next;

    logic [RCW-1:0]      eff_rows;
    logic [CCW-1:0]      eff_cols;
    logic [MAX_COLS-1:0] col_mask;
    logic [RCW-1:0]      row_ext;
    logic [RCW-1:0]      in_row_ext;
    logic [CCW-1:0]      col_ext;
    logic                in_area;
    logic [RCW-1:0]      below_idx;
    logic [RCW:0]        read2_idx;
    logic [MAX_COLS-1:0] below;
    logic [MAX_COLS-1:0] patched_row;

    logic                mem_wr_en;
    logic [RW-1:0]       mem_wr_addr;
    logic [MAX_COLS-1:0] mem_wr_data;
    logic [RW-1:0]       mem_rd_addr;
    logic [MAX_COLS-1:0] mem_rd_data;
    logic [MAX_COLS-1:0] unit_new_row;
    logic                unit_changed;

    lgs_grid_mem #(
        .ROWS (MAX_ROWS),
        .COLS (MAX_COLS)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    lgs_row_unit #(
        .COLS (MAX_COLS)
    ) u_row (
        .above    (above_reg),
        .cur      (cur_reg),
        .below    (below),
        .col_mask (col_mask),
        .new_row  (unit_new_row),
        .changed  (unit_changed)
    );

    // Effective area: register values saturate at the grid size.
    always_comb
    begin
        eff_rows = (RCW'(rows_in_use_reg) > RCW'(MAX_ROWS)) ? RCW'(MAX_ROWS)
                                                           : RCW'(rows_in_use_reg);
        eff_cols = (CCW'(cols_in_use_reg) > CCW'(MAX_COLS)) ? CCW'(MAX_COLS)
                                                           : CCW'(cols_in_use_reg);
        for (int c = 0; c < MAX_COLS; c++)
        begin
            col_mask[c] = CCW'(c) < eff_cols;
        end
    end

    always_comb
    begin
        row_ext     = RCW'(req_row_reg);
        in_row_ext  = RCW'(row);
        col_ext     = CCW'(req_col_reg);
        in_area     = (row_ext < eff_rows) && (col_ext < eff_cols);
        below_idx   = RCW'(sweep_row_reg) + RCW'(1);
        read2_idx   = (RCW + 1)'(sweep_row_reg) + (RCW + 1)'(2);
        below       = (below_idx < eff_rows) ? mem_rd_data : '0;
        patched_row = mem_rd_data;
        patched_row[col_ext[CW-1:0]] = req_value_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        req_cmd_next   = req_cmd_reg;
        req_row_next   = req_row_reg;
        req_col_next   = req_col_reg;
        req_value_next = req_value_reg;
        sweep_row_next = sweep_row_reg;
        above_next     = above_reg;
        cur_next       = cur_reg;
        diff_next      = diff_reg;
        done_next      = 1'b0;
        cell_res_next  = cell_res_reg;
        stable_next    = stable_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = row_ext[RW-1:0];
        mem_wr_data    = patched_row;
        mem_rd_addr    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                mem_rd_addr = in_row_ext[RW-1:0];
                if (start)
                begin
                    req_cmd_next   = cmd;
                    req_row_next   = row;
                    req_col_next   = col;
                    req_value_next = value;
                    case (cmd)
                        CMD_WRITE, CMD_READ:
                        begin
                            state_next = ST_CELL;
                        end
                        CMD_STEP:
                        begin
                            mem_rd_addr = '0;
                            if (eff_rows == '0)
                            begin
                                done_next     = 1'b1;
                                cell_res_next = 1'b0;
                                stable_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_LOAD;
                            end
                        end
                        default:
                        begin
                            done_next     = 1'b1;
                            cell_res_next = 1'b0;
                            stable_next   = 1'b0;
                        end
                    endcase
                end
            end
            ST_CELL:
            begin
                // The addressed row is on the read port; patch it for a write.
                mem_wr_en     = (req_cmd_reg == CMD_WRITE) && in_area;
                done_next     = 1'b1;
                cell_res_next = (req_cmd_reg == CMD_READ) && in_area
                                && mem_rd_data[col_ext[CW-1:0]];
                stable_next   = 1'b0;
                state_next    = ST_IDLE;
            end
            ST_LOAD:
            begin
                above_next     = '0;
                cur_next       = mem_rd_data;
                sweep_row_next = '0;
                diff_next      = 1'b0;
                mem_rd_addr    = RW'(1);
                state_next     = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                // Row r is replaced while row r+1 is on the read port and r+2 is fetched.
                mem_wr_en   = 1'b1;
                mem_wr_addr = sweep_row_reg;
                mem_wr_data = unit_new_row;
                if (read2_idx < (RCW + 1)'(MAX_ROWS))
                begin
                    mem_rd_addr = read2_idx[RW-1:0];
                end
                if (below_idx == eff_rows)
                begin
                    done_next     = 1'b1;
                    cell_res_next = 1'b0;
                    stable_next   = !(diff_reg || unit_changed);
                    state_next    = ST_IDLE;
                end
                else
                begin
                    diff_next      = diff_reg || unit_changed;
                    sweep_row_next = sweep_row_reg + RW'(1);
                    above_next     = cur_reg;
                    cur_next       = below;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            done_reg        <= 1'b0;
            cols_in_use_reg <= COLS_RESET;
            rows_in_use_reg <= ROWS_RESET;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_COLS: cols_in_use_reg <= cfg_wdata[COLS_W-1:0];
                    REG_ROWS: rows_in_use_reg <= cfg_wdata[ROWS_W-1:0];
                    default:  cols_in_use_reg <= cols_in_use_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_cmd_reg   <= req_cmd_next;
        req_row_reg   <= req_row_next;
        req_col_reg   <= req_col_next;
        req_value_reg <= req_value_next;
        sweep_row_reg <= sweep_row_next;
        above_reg     <= above_next;
        cur_reg       <= cur_next;
        diff_reg      <= diff_next;
        cell_res_reg  <= cell_res_next;
        stable_reg    <= stable_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign cell_res = done_reg & cell_res_reg;
    assign stable   = done_reg & stable_reg;

`ifndef SYNTHESIS
    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while the sequencer is busy");

    a_sweep_in_area: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (RCW'(sweep_row_reg) < eff_rows))
        else $error("sweep row outside the area in use");

    a_read_only_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && cell_res) |-> (req_cmd_reg == CMD_READ))
        else $error("cell value reported for a command other than read");

    a_step_only_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (done && stable) |-> (req_cmd_reg == CMD_STEP))
        else $error("stable flag reported for a command other than step");

    a_load_then_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |=> (state_reg == ST_SWEEP))
        else $error("load cycle not followed by the row sweep");
`endif

endmodule

`default_nettype wire

// ===== verif/life_grid_generation_step_tb.sv =====
// Testbench for life_grid_generation_step: a directed table, then random command phases
// over several grid sizes, every result checked against the table or a B3/S23 grid model kept here.
// Depends on lgs_pkg and the RTL of life_grid_generation_step.
`default_nettype none

module life_grid_generation_step_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lgs_pkg::*;

    localparam int GRID_COLS = 64;
    localparam int GRID_ROWS = 32;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_SET_COLS,
        ROW_SET_ROWS
    } dir_kind_t;

    typedef struct packed {
        dir_kind_t             kind;
        logic [CMD_W-1:0]      op;
        logic [ROW_W-1:0]      r;
        logic [COL_W-1:0]      c;
        logic                  v;
        logic [CFG_DATA_W-1:0] cfg;
        logic                  typed;
        logic                  exp_cell;
        logic                  exp_stable;
    } dir_row_t;

    typedef struct packed {
        logic             cell_res;
        logic             stable;
        logic [CMD_W-1:0] op;
    } grid_answer_t;

    localparam int DIR_N = 35;

    // Rows with typed = 1 carry their expected result; the others use the grid model.
    dir_row_t directed_rows [DIR_N] = '{
        '{ROW_ITEM,     CMD_READ,   5'd0,  6'd0,  1'b0, 7'd0,   1'b1, 1'b0, 1'b0},
        '{ROW_ITEM,     CMD_STEP,   5'd0,  6'd0,  1'b0, 7'd0,   1'b1, 1'b0, 1'b1},
        '{ROW_ITEM,     CMD_WRITE,  5'd31, 6'd63, 1'b1, 7'd0,   1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,     CMD_READ,   5'd31, 6'd63, 1'b0, 7'd0,   1'b1, 1'b0, 1'b0},
        '{ROW_ITEM,     CMD_WRITE,  5'd0,  6'd0,  1'b1, 7'd0,   1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,     CMD_READ,   5'd0,  6'd0,  1'b0, 7'd0,   1'b1, 1'b1, 1'b0},
        '{ROW_ITEM,     CMD_WRITE,  5'd29, 6'd59, 1'b1, 7'd0,   1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,     CMD_READ,   5'd29, 6'd59, 1'b0, 7'd0,   1'b1, 1'b1, 1'b0},
        '{ROW_ITEM,     CMD_UNUSED, 5'd31, 6'd63, 1'b1, 7'd0,   1'b1, 1'b0, 1'b0},
        '{ROW_ITEM,     CMD_WRITE,  5'd10, 6'd4,  1'b1, 7'd0,   1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,     CMD_WRITE,  5'd10, 6'd5,  1'b1, 7'd0,   1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,     CMD_WRITE,  5'd10, 6'd6,  1'b1, 7'd0,   1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,     CMD_STEP,   5'd0,  6'd0,  1'b0, 7'd0,   1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,     CMD_READ,   5'd9,  6'd5,  1'b0, 7'd0,   1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,     CMD_READ,   5'd10, 6'd4,  1'b0, 7'd0,   1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,     CMD_STEP,   5'd0,  6'd0,  1'b0, 7'd0,   1'b0, 1'b0, 1'b0},
        '{ROW_SET_COLS, CMD_WRITE,  5'd0,  6'd0,  1'b0, 7'd127, 1'b0, 1'b0, 1'b0},
        '{ROW_SET_ROWS, CMD_WRITE,  5'd0,  6'd0,  1'b0, 7'd127, 1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,     CMD_WRITE,  5'd31, 6'd63, 1'b1, 7'd0,   1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,     CMD_READ,   5'd31, 6'd63, 1'b0, 7'd0,   1'b0, 1'b0, 1'b0},
        '{ROW_SET_COLS, CMD_WRITE,  5'd0,  6'd0,  1'b0, 7'd3,   1'b0, 1'b0, 1'b0},
        '{ROW_SET_ROWS, CMD_WRITE,  5'd0,  6'd0,  1'b0, 7'd3,   1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,     CMD_READ,   5'd31, 6'd63, 1'b0, 7'd0,   1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,     CMD_WRITE,  5'd0,  6'd1,  1'b1, 7'd0,   1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,     CMD_WRITE,  5'd1,  6'd1,  1'b1, 7'd0,   1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,     CMD_WRITE,  5'd2,  6'd1,  1'b1, 7'd0,   1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,     CMD_STEP,   5'd0,  6'd0,  1'b0, 7'd0,   1'b0, 1'b0, 1'b0},
        '{ROW_SET_COLS, CMD_WRITE,  5'd0,  6'd0,  1'b0, 7'd0,   1'b0, 1'b0, 1'b0},
        '{ROW_SET_ROWS, CMD_WRITE,  5'd0,  6'd0,  1'b0, 7'd0,   1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,     CMD_STEP,   5'd0,  6'd0,  1'b0, 7'd0,   1'b1, 1'b0, 1'b1},
        '{ROW_ITEM,     CMD_READ,   5'd0,  6'd1,  1'b0, 7'd0,   1'b1, 1'b0, 1'b0},
        '{ROW_SET_COLS, CMD_WRITE,  5'd0,  6'd0,  1'b0, 7'd64,  1'b0, 1'b0, 1'b0},
        '{ROW_SET_ROWS, CMD_WRITE,  5'd0,  6'd0,  1'b0, 7'd32,  1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,     CMD_READ,   5'd31, 6'd63, 1'b0, 7'd0,   1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,     CMD_STEP,   5'd0,  6'd0,  1'b0, 7'd0,   1'b0, 1'b0, 1'b0}
    };

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic [CMD_W-1:0]      cmd       = CMD_WRITE;
    logic [ROW_W-1:0]      row       = '0;
    logic [COL_W-1:0]      col       = '0;
    logic                  value     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_COLS;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  busy;
    logic                  done;
    logic                  cell_res;
    logic                  stable;

    // Grid model and its copy of the size registers.
    logic [GRID_COLS-1:0] life_grid [GRID_ROWS];
    logic [COLS_W-1:0]    cols_reg;
    logic [ROWS_W-1:0]    rows_reg;

    grid_answer_t grid_answers_q [$];

    int errors       = 0;
    int n_writes     = 0;
    int n_reads      = 0;
    int n_steps      = 0;
    int n_unused     = 0;
    int n_still      = 0;
    int n_sizes      = 0;
    bit no_gaps      = 1'b0;
    int win_row      = 0;
    int win_col      = 0;

    life_grid_generation_step DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .row       (row),
        .col       (col),
        .value     (value),
        .busy      (busy),
        .done      (done),
        .cell_res  (cell_res),
        .stable    (stable),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int area_cols();
        return (cols_reg > GRID_COLS) ? GRID_COLS : int'(cols_reg);
    endfunction

    function automatic int area_rows();
        return (rows_reg > GRID_ROWS) ? GRID_ROWS : int'(rows_reg);
    endfunction

    // One B3/S23 generation over the area in use; returns 1 when nothing changed.
    function automatic bit life_generation();
        logic [GRID_COLS-1:0] nxt [GRID_ROWS];
        int nr, nc, r, c, dr, dc, rr, cc, n;
        bit alive, same;
        nr = area_rows();
        nc = area_cols();
        same = 1'b1;
        nxt = life_grid;
        for (r = 0; r < nr; r++)
        begin
            for (c = 0; c < nc; c++)
            begin
                n = 0;
                for (dr = -1; dr <= 1; dr++)
                begin
                    for (dc = -1; dc <= 1; dc++)
                    begin
                        rr = r + dr;
                        cc = c + dc;
                        if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < nr && cc < nc)
                            n += int'(life_grid[rr][cc]);
                    end
                end
                alive = life_grid[r][c] ? (n == 2 || n == 3) : (n == 3);
                nxt[r][c] = alive;
                if (alive != life_grid[r][c])
                    same = 1'b0;
            end
        end
        life_grid = nxt;
        return same;
    endfunction

    function automatic void grid_apply_cmd(input logic [CMD_W-1:0] op,
                                           input logic [ROW_W-1:0] r,
                                           input logic [COL_W-1:0] c,
                                           input logic v,
                                           output logic cell_o,
                                           output logic stable_o);
        bit in_area;
        in_area = (int'(r) < area_rows()) && (int'(c) < area_cols());
        cell_o = 1'b0;
        stable_o = 1'b0;
        case (op)
            CMD_WRITE: if (in_area) life_grid[r][c] = v;
            CMD_READ:  if (in_area) cell_o = life_grid[r][c];
            CMD_STEP:  stable_o = life_generation();
            default:   ;
        endcase
    endfunction

    // Presents one command, waits for the transfer and records what must come back.
    task automatic issue_cmd(input logic [CMD_W-1:0] op, input logic [ROW_W-1:0] r,
                             input logic [COL_W-1:0] c, input logic v,
                             input logic typed, input logic exp_cell, input logic exp_stable);
        int gap;
        logic pc, ps;
        gap = no_gaps ? 0 : int'($urandom_range(0, 17));
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= op;
        row   <= r;
        col   <= c;
        value <= v;
        do @(posedge clk); while (busy);
        grid_apply_cmd(op, r, c, v, pc, ps);
        if (typed)
        begin
            pc = exp_cell;
            ps = exp_stable;
        end
        grid_answers_q.push_back('{pc, ps, op});
        case (op)
            CMD_WRITE: n_writes++;
            CMD_READ:  n_reads++;
            CMD_STEP:  n_steps++;
            default:   n_unused++;
        endcase
    endtask

    // Size registers change only with the block idle and nothing outstanding.
    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        start <= 1'b0;
        while (grid_answers_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_COLS)
            cols_reg = data[COLS_W-1:0];
        else
        begin
            rows_reg = data[ROWS_W-1:0];
            n_sizes++;
        end
    endtask

    // Mostly near the seeded window so reads and writes meet live cells.
    task automatic pick_spot(output logic [ROW_W-1:0] r, output logic [COL_W-1:0] c);
        int a, nr, nc;
        a = int'($urandom_range(0, 19));
        nr = area_rows();
        nc = area_cols();
        if (a < 14)
        begin
            r = ROW_W'(win_row + int'($urandom_range(0, 5)));
            c = COL_W'(win_col + int'($urandom_range(0, 5)));
        end
        else if (a < 17 && nr > 0 && nc > 0)
        begin
            r = ROW_W'($urandom_range(0, nr - 1));
            c = COL_W'($urandom_range(0, nc - 1));
        end
        else
        begin
            r = ROW_W'($urandom_range(0, 31));
            c = COL_W'($urandom_range(0, 63));
        end
    endtask

    always @(posedge clk)
    begin : watch_results
        grid_answer_t want;
        if (rst_n && done)
        begin
            if (grid_answers_q.size() == 0)
            begin
                $display("%0t: result with no command outstanding: cell_res=%0b stable=%0b",
                         $time, cell_res, stable);
                errors++;
            end
            else
            begin
                want = grid_answers_q.pop_front();
                if (cell_res !== want.cell_res)
                begin
                    $display("%0t: cell_res mismatch (cmd %0d): expected %0b, actual %0b",
                             $time, want.op, want.cell_res, cell_res);
                    errors++;
                end
                if (stable !== want.stable)
                begin
                    $display("%0t: stable mismatch (cmd %0d): expected %0b, actual %0b",
                             $time, want.op, want.stable, stable);
                    errors++;
                end
                if (want.op == CMD_STEP && stable === 1'b1)
                    n_still++;
            end
        end
    end

    initial
    begin
        int i, ph, k, sel, guard, nr, nc;
        logic [CFG_DATA_W-1:0] pc, pr;
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        logic [CMD_W-1:0] op;

        foreach (life_grid[j])
            life_grid[j] = '0;
        cols_reg = COLS_RESET;
        rows_reg = ROWS_RESET;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_N; i++)
        begin
            case (directed_rows[i].kind)
                ROW_SET_COLS: set_register(REG_COLS, directed_rows[i].cfg);
                ROW_SET_ROWS: set_register(REG_ROWS, directed_rows[i].cfg);
                default:
                    issue_cmd(directed_rows[i].op, directed_rows[i].r, directed_rows[i].c,
                              directed_rows[i].v, directed_rows[i].typed,
                              directed_rows[i].exp_cell, directed_rows[i].exp_stable);
            endcase
        end

        for (ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: begin pc = 7'd64;  pr = 7'd32;  end
                1: begin pc = 7'd3;   pr = 7'd3;   end
                2: begin pc = 7'd127; pr = 7'd127; end
                3: begin pc = 7'd0;   pr = 7'd0;   end
                4: begin pc = 7'd65;  pr = 7'd33;  end
                default:
                begin
                    pc = CFG_DATA_W'($urandom_range(3, 64));
                    pr = CFG_DATA_W'($urandom_range(3, 32));
                end
            endcase
            set_register(REG_COLS, pc);
            set_register(REG_ROWS, pr);
            no_gaps = ($urandom_range(0, 3) == 0);
            nr = area_rows();
            nc = area_cols();
            win_row = (nr > 6) ? int'($urandom_range(0, nr - 6)) : 0;
            win_col = (nc > 6) ? int'($urandom_range(0, nc - 6)) : 0;

            // Seed a small patch, then mix commands so the pattern evolves while probed.
            for (k = 0; k < 16; k++)
            begin
                r = ROW_W'(win_row + int'($urandom_range(0, 5)));
                c = COL_W'(win_col + int'($urandom_range(0, 5)));
                issue_cmd(CMD_WRITE, r, c, ($urandom_range(0, 9) < 6), 1'b0, 1'b0, 1'b0);
            end
            for (k = 0; k < 34; k++)
            begin
                sel = int'($urandom_range(0, 19));
                pick_spot(r, c);
                if (sel < 7)
                    op = CMD_WRITE;
                else if (sel < 12)
                    op = CMD_READ;
                else if (sel < 19)
                    op = CMD_STEP;
                else
                    op = CMD_UNUSED;
                issue_cmd(op, r, c, 1'($urandom_range(0, 1)), 1'b0, 1'b0, 1'b0);
            end
        end

        start <= 1'b0;
        guard = 0;
        while (grid_answers_q.size() != 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        if (grid_answers_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, grid_answers_q.size());
            errors += grid_answers_q.size();
        end
        repeat (40) @(posedge clk);

        $display("Ran %0d writes, %0d reads, %0d generation steps and %0d unused commands",
                 n_writes, n_reads, n_steps, n_unused);
        $display("across %0d grid sizes; %0d steps found the grid unchanged, %0d errors",
                 n_sizes, n_still, errors);
        if (errors == 0)
            $display("life_grid_generation_step_tb OK");
        else
            $display("life_grid_generation_step_tb NOT OK");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("%0t: run did not complete in time", $time);
        $display("life_grid_generation_step_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
